### hw/rtl/stc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stc_pkg;

  localparam int VEC_FRAC_BITS = 14;
  localparam int VW    = 16;
  localparam int TW    = 15;
  localparam int PW    = 24;
  localparam int RADW  = 16;
  localparam int RADF  = 8;
  localparam logic [RADW-1:0] RAD_RESET = RADW'(256);

  // normalizer widths
  localparam int SW    = VW + 1;
  localparam int AW    = SW;
  localparam int QW    = 2 * AW;
  localparam int RW    = QW / 2;
  localparam int SQ_STEPS = QW / 2;
  localparam int QB    = VEC_FRAC_BITS + 1;
  localparam int NW    = AW + VEC_FRAC_BITS + 2;
  localparam int NSTEP_MAX = (SQ_STEPS > QB) ? SQ_STEPS : QB;
  localparam int CNTW  = $clog2(NSTEP_MAX + 1);
  localparam int VLIM  = ((1 << VEC_FRAC_BITS) < 32767) ? (1 << VEC_FRAC_BITS) : 32767;

  localparam int PM    = VW + RADW + 1;
  localparam int NVERT = 12;
  localparam int KW    = $clog2(NVERT);

  typedef struct packed {
    logic [2:0][VW-1:0] t;
    logic [1:0][TW-1:0] tc;
    logic [2:0][VW-1:0] n;
  } vert_t;

  typedef struct packed {
    logic [RADW-1:0] rad;
    vert_t [2:0]     c;
  } job_t;

  typedef struct packed {
    logic             last;
    vert_t            v;
    logic [2:0][PW-1:0] pos;
  } out_t;

  // source vertex of each emitted vertex: v0,v3,v5, v3,v1,v4, v4,v2,v5, v3,v4,v5
  function automatic logic [2:0] emit_idx(input logic [KW-1:0] k);
    logic [2:0] r;
    case (k)
      4'd0:  r = 3'd0;
      4'd1:  r = 3'd3;
      4'd2:  r = 3'd5;
      4'd3:  r = 3'd3;
      4'd4:  r = 3'd1;
      4'd5:  r = 3'd4;
      4'd6:  r = 3'd4;
      4'd7:  r = 3'd2;
      4'd8:  r = 3'd5;
      4'd9:  r = 3'd3;
      4'd10: r = 3'd4;
      4'd11: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sphere_triangle_subdivider_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Arithmetic: every triangle goes through the one shared normalizer, six vectors each with
//   17 square-root and 15 division steps; an edge sum or a midpoint tangent that is zero
//   skips both.
// Reset: rst_ni is asynchronous, active low; clears the corner count and queue, and
//   sets the radius to 1.0. No clearing pass.
module sphere_triangle_subdivider_top import stc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // nx[15:0] ny[31:16] nz[47:32] u[62:48] v[77:63] tx[93:78] ty[109:94] tz[125:110]
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // px[23:0] py[47:24] pz[71:48] nx[87:72] ny[103:88] nz[119:104] u[134:120]
  // v[149:135] tx[165:150] ty[181:166] tz[197:182]
  output logic [199:0]      m_axis_tdata,
  output logic              m_axis_tlast,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i
);

  vert_t in_vert;
  job_t  push_job, head_job;
  logic  push, full, qvalid, pop;
  out_t  res;

  // unpack the incoming corner
  always_comb begin
    in_vert.n[0]  = s_axis_tdata[15:0];
    in_vert.n[1]  = s_axis_tdata[31:16];
    in_vert.n[2]  = s_axis_tdata[47:32];
    in_vert.tc[0] = s_axis_tdata[62:48];
    in_vert.tc[1] = s_axis_tdata[77:63];
    in_vert.t[0]  = s_axis_tdata[93:78];
    in_vert.t[1]  = s_axis_tdata[109:94];
    in_vert.t[2]  = s_axis_tdata[125:110];
  end

  // front: hold corners, capture the radius, hand complete triangles on
  stc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_vert_i   (in_vert),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // two-deep triangle queue decouples intake from the arithmetic
  stc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (qvalid),
    .pop_i   (pop),
    .head_o  (head_job)
  );

  // back: midpoints, positions, and the twelve-vertex emission
  stc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qvalid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {2'b00, res.v.t[2], res.v.t[1], res.v.t[0],
                         res.v.tc[1], res.v.tc[0],
                         res.v.n[2], res.v.n[1], res.v.n[0],
                         res.pos[2], res.pos[1], res.pos[0]};

endmodule
`default_nettype wire

### hw/rtl/stc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module stc_front import stc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire vert_t           in_vert_i,
  input  wire logic            cfg_we_i,
  input  wire logic [RADW-1:0] cfg_wdata_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output job_t                 job_o
);

  logic [1:0]      cnt_q, cnt_d;
  logic [RADW-1:0] rad_q;
  vert_t           hold_q [2];
  logic            acc;

  assign in_ready_o = (cnt_q != 2'd2) || !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = acc && (cnt_q == 2'd2);

  always_comb begin
    cnt_d = cnt_q;
    if (acc) begin
      cnt_d = (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
    end
  end

  always_comb begin
    job_o.c[0] = hold_q[0];
    job_o.c[1] = hold_q[1];
    job_o.c[2] = in_vert_i;
    job_o.rad  = rad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rad_q <= RAD_RESET;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        rad_q <= cfg_wdata_i;
      end
    end
  end

  // hold the first two corners
  always_ff @(posedge clk_i) begin
    if (acc && (cnt_q != 2'd2)) begin
      hold_q[cnt_q[0]] <= in_vert_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/stc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module stc_queue import stc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output job_t      head_o
);

  job_t       mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wp_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/stc_norm.sv
`timescale 1ns / 1ps
`default_nettype none
module stc_norm import stc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [2:0][SW-1:0]  vec_i,
  output logic                     done_o,
  output logic [2:0][VW-1:0]       res_o
);

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SQ   = 3'd1;
  localparam logic [2:0] N_SUM  = 3'd2;
  localparam logic [2:0] N_SQRT = 3'd3;
  localparam logic [2:0] N_DIV  = 3'd4;

  logic [2:0]          st_q, st_d;
  logic                done_q, done_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic [2:0][AW-1:0]  a_q, a_d;
  logic [2:0]          neg_q, neg_d;
  logic [2:0][QW-1:0]  sq_q, sq_d;
  logic [QW-1:0]       x_q, x_d, r_q, r_d, bit_q, bit_d;
  logic [2:0][NW-1:0]  n_q, n_d;
  logic [NW-1:0]       dsh_q, dsh_d;
  logic [2:0][QB-1:0]  quo_q, quo_d;
  logic [2:0][VW-1:0]  res_q, res_d;
  logic [QW-1:0]       sum;
  logic [QW:0]         trial;
  logic [RW-1:0]       len;
  logic [QB-1:0]       qc;
  logic [VW-1:0]       mag;

  assign done_o = done_q;
  assign res_o  = res_q;

  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    neg_d  = neg_q;
    sq_d   = sq_q;
    x_d    = x_q;
    r_d    = r_q;
    bit_d  = bit_q;
    n_d    = n_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    res_d  = res_q;
    sum    = sq_q[0] + sq_q[1] + sq_q[2];
    trial  = {1'b0, r_q} + {1'b0, bit_q};
    len    = '0;
    qc     = '0;
    mag    = '0;
    case (st_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            neg_d[i] = vec_i[i][SW-1];
            a_d[i]   = vec_i[i][SW-1] ? AW'(-vec_i[i]) : AW'(vec_i[i]);
          end
          st_d = N_SQ;
        end
      end
      N_SQ: begin
        for (int i = 0; i < 3; i++) begin
          sq_d[i] = QW'(a_q[i]) * QW'(a_q[i]);
        end
        st_d = N_SUM;
      end
      N_SUM: begin
        if (sum == '0) begin
          res_d  = '0;
          done_d = 1'b1;
          st_d   = N_IDLE;
        end else begin
          x_d   = sum;
          r_d   = '0;
          bit_d = QW'(1) << (QW - 2);
          cnt_d = CNTW'(SQ_STEPS);
          st_d  = N_SQRT;
        end
      end
      N_SQRT: begin
        // one root bit a step
        if ({1'b0, x_q} >= trial) begin
          x_d = x_q - trial[QW-1:0];
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          len   = r_d[RW-1:0];
          for (int i = 0; i < 3; i++) begin
            n_d[i]   = (NW'(a_q[i]) << (VEC_FRAC_BITS + 1)) + NW'(len);
            quo_d[i] = '0;
          end
          dsh_d = NW'(len) << (VEC_FRAC_BITS + 1);
          cnt_d = CNTW'(QB);
          st_d  = N_DIV;
        end
      end
      N_DIV: begin
        // one quotient bit a step in each lane
        for (int i = 0; i < 3; i++) begin
          if (n_q[i] >= dsh_q) begin
            n_d[i]   = n_q[i] - dsh_q;
            quo_d[i] = {quo_q[i][QB-2:0], 1'b1};
          end else begin
            quo_d[i] = {quo_q[i][QB-2:0], 1'b0};
          end
        end
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          for (int i = 0; i < 3; i++) begin
            qc       = (quo_d[i] > QB'(VLIM)) ? QB'(VLIM) : quo_d[i];
            mag      = VW'(qc);
            res_d[i] = neg_q[i] ? -mag : mag;
          end
          done_d = 1'b1;
          st_d   = N_IDLE;
        end
      end
      default: st_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= N_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    neg_q <= neg_d;
    sq_q  <= sq_d;
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
    n_q   <= n_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    res_q <= res_d;
  end

endmodule
`default_nettype wire

### hw/rtl/stc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module stc_back import stc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  wire job_t job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_PMUL   = 3'd1;
  localparam logic [2:0] B_PWR    = 3'd2;
  localparam logic [2:0] B_NSTART = 3'd3;
  localparam logic [2:0] B_NWAIT  = 3'd4;
  localparam logic [2:0] B_TSTART = 3'd5;
  localparam logic [2:0] B_TWAIT  = 3'd6;
  localparam logic [2:0] B_EMIT   = 3'd7;

  logic [2:0]          st_q, st_d;
  logic [2:0]          vi_q, vi_d;
  logic [KW-1:0]       k_q, k_d;
  logic                ov_q, ov_d;
  out_t                out_q;
  vert_t               mid_q [3];
  logic [2:0][PW-1:0]  pos_q [6];
  logic [2:0][PM-1:0]  prod_q;
  logic [2:0]          rd_idx;
  logic [1:0]          m;
  vert_t               vv, va, vb;
  logic                load;
  logic                n_start, n_done;
  logic [2:0][SW-1:0]  n_vec;
  logic [2:0][VW-1:0]  n_res;

  function automatic logic [PW-1:0] place_sat(input logic [PM-1:0] p);
    logic [PM-1:0] a;
    logic [PM-1:0] r;
    logic [PW-1:0] o;
    a = p[PM-1] ? -p : p;
    r = (a + PM'(1 << (RADF - 1))) >> RADF;
    if (p[PM-1]) begin
      o = (r > PM'(1 << (PW - 1))) ? {1'b1, {(PW-1){1'b0}}} : PW'(-r);
    end else begin
      o = (r > PM'((1 << (PW - 1)) - 1)) ? {1'b0, {(PW-1){1'b1}}} : PW'(r);
    end
    return o;
  endfunction

  stc_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (n_start),
    .vec_i   (n_vec),
    .done_o  (n_done),
    .res_o   (n_res)
  );

  assign m      = 2'(vi_q - 3'd3);
  assign rd_idx = (st_q == B_EMIT) ? emit_idx(k_q) : vi_q;
  assign load   = (st_q == B_EMIT) && (!ov_q || out_ready_i);
  assign pop_o  = load && (k_q == KW'(NVERT - 1));

  // vertex view: corners from the queue head, midpoints from local regs
  always_comb begin
    case (rd_idx)
      3'd0:    vv = job_i.c[0];
      3'd1:    vv = job_i.c[1];
      3'd2:    vv = job_i.c[2];
      3'd3:    vv = mid_q[0];
      3'd4:    vv = mid_q[1];
      default: vv = mid_q[2];
    endcase
  end

  // edge endpoints of the current midpoint
  always_comb begin
    case (m)
      2'd0:    begin va = job_i.c[0]; vb = job_i.c[1]; end
      2'd1:    begin va = job_i.c[1]; vb = job_i.c[2]; end
      default: begin va = job_i.c[2]; vb = job_i.c[0]; end
    endcase
  end

  always_comb begin
    n_start = 1'b0;
    n_vec   = '0;
    if (st_q == B_NSTART) begin
      n_start = 1'b1;
      for (int i = 0; i < 3; i++) begin
        n_vec[i] = {va.n[i][VW-1], va.n[i]} + {vb.n[i][VW-1], vb.n[i]};
      end
    end else if (st_q == B_TSTART) begin
      n_start  = 1'b1;
      n_vec[0] = {vv.n[2][VW-1], vv.n[2]};
      n_vec[2] = -{vv.n[0][VW-1], vv.n[0]};
    end
  end

  always_comb begin
    st_d = st_q;
    vi_d = vi_q;
    k_d  = k_q;
    ov_d = ov_q;
    if (out_ready_i) begin
      ov_d = 1'b0;
    end
    case (st_q)
      B_IDLE: begin
        if (job_valid_i) begin
          vi_d = 3'd0;
          st_d = B_PMUL;
        end
      end
      B_PMUL:   st_d = B_PWR;
      B_PWR: begin
        if (vi_q == 3'd5) begin
          k_d  = '0;
          st_d = B_EMIT;
        end else begin
          vi_d = vi_q + 3'd1;
          st_d = (vi_q < 3'd2) ? B_PMUL : B_NSTART;
        end
      end
      B_NSTART: st_d = B_NWAIT;
      B_NWAIT:  if (n_done) st_d = B_TSTART;
      B_TSTART: st_d = B_TWAIT;
      B_TWAIT:  if (n_done) st_d = B_PMUL;
      B_EMIT: begin
        if (load) begin
          ov_d = 1'b1;
          if (k_q == KW'(NVERT - 1)) begin
            st_d = B_IDLE;
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
      vi_q <= '0;
      k_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      vi_q <= vi_d;
      k_q  <= k_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == B_PMUL) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= PM'($signed(vv.n[i])) * PM'($signed({1'b0, job_i.rad}));
      end
    end
    if (st_q == B_PWR) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[vi_q][i] <= place_sat(prod_q[i]);
      end
    end
    if (st_q == B_NSTART) begin
      for (int i = 0; i < 2; i++) begin
        mid_q[m].tc[i] <= TW'(({1'b0, va.tc[i]} + {1'b0, vb.tc[i]}) >> 1);
      end
    end
    if ((st_q == B_NWAIT) && n_done) begin
      mid_q[m].n <= n_res;
    end
    if ((st_q == B_TWAIT) && n_done) begin
      mid_q[m].t <= n_res;
    end
    if (load) begin
      out_q.v    <= vv;
      out_q.pos  <= pos_q[rd_idx];
      out_q.last <= (k_q == KW'(NVERT - 1));
    end
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire
